// ===== design/point_near_great_circle_arc_test_top_defines.svh =====
// assertion macros for the point near arc test block
// used by point_near_great_circle_arc_test_top; needs clk and rst in scope
`ifndef POINT_NEAR_GREAT_CIRCLE_ARC_TEST_TOP_DEFINES_SVH
`define POINT_NEAR_GREAT_CIRCLE_ARC_TEST_TOP_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define PNGA_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("pnga assertion failed");

// implication after a fixed number of cycles
`define PNGA_ASSERT_DELAY(label, cond, n, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##(n) (prop)) \
    else $error("pnga latency assertion failed");

`endif

// ===== design/pnga_pkg.sv =====
// shared types, constants and arithmetic helpers for the point near arc test
// no dependencies
`timescale 1ns / 1ps

package pnga_pkg;

  // fixed-point format of every vector component
  localparam int FRAC_BITS = 30;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DOT_W     = SUM_W - FRAC_BITS;
  localparam int SHIFT_W   = PROD_W - FRAC_BITS;
  localparam int PROJ_W    = SHIFT_W + 1;
  localparam int MAG_W     = 31;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int ROOT_W    = 32;
  localparam int Q_W       = FRAC_BITS + 1;

  // pipeline depth of each section
  localparam int FRONT_STAGES = 7;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int DIV_STAGES   = Q_W;
  localparam int BACK_STAGES  = 3;
  localparam int LATENCY = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + BACK_STAGES;

  // configuration register indexes
  localparam logic REG_INCLUSION = 1'b0;
  localparam logic REG_LATITUDE  = 1'b1;

  localparam logic signed [WORD_W-1:0] INCLUSION_RESET = 32'sd1073741824;
  localparam logic [30:0]              LATITUDE_RESET  = 31'd1073741824;

  typedef enum logic [1:0] {
    KIND_EXCLUDED = 2'd0,
    KIND_INTERIOR = 2'd1,
    KIND_START    = 2'd2,
    KIND_END      = 2'd3
  } kind_t;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [2:0]              vec3_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic [2:0][MAG_W-1:0]    mag3_t;

  typedef struct packed {
    word_t point_x;
    word_t point_y;
    word_t point_z;
    word_t start_x;
    word_t start_y;
    word_t start_z;
    word_t end_x;
    word_t end_y;
    word_t end_z;
    word_t axis_x;
    word_t axis_y;
    word_t axis_z;
  } in_t;

  typedef struct packed {
    logic              is_close;
    logic signed [31:0] closeness;
    logic [1:0]        nearest_kind;
  } res_t;

  // data that rides along the root and divider pipelines
  typedef struct packed {
    vec3_t t;
    vec3_t a;
    vec3_t b;
    dot_t  ab;
    dot_t  ta;
    dot_t  tb;
    logic [2:0] neg;
    mag3_t mag;
    logic  excl;
  } mid_t;

  // full signed product of two components
  function automatic prod_t mul32(input word_t x, input word_t y);
    return PROD_W'(x) * PROD_W'(y);
  endfunction

  // exact sum of three products, floored by the fraction width
  function automatic dot_t dot_sum(input prod_t p0, input prod_t p1, input prod_t p2);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
    return s[SUM_W-1:FRAC_BITS];
  endfunction

  // clamp a dot product into a signed word
  function automatic word_t sat_word(input dot_t v);
    word_t r;
    if (!v[DOT_W-1] && (|v[DOT_W-2:WORD_W-1])) begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v[DOT_W-1] && !(&v[DOT_W-2:WORD_W-1])) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/point_near_great_circle_arc_test_top.sv =====
// each accepted transaction passes through the front, square root, divider and back sections to the result strobe
// throughput: one transaction per cycle; busy is high only during reset
// the depth is set mostly by the 32-stage square root and the 31-stage divider pipelines
// results are strobed for one cycle and the receiver cannot stall them
// reset clears all pipeline valid bits and restores both threshold registers
// depends on pnga_pkg, pnga_front, pnga_isqrt, pnga_div, pnga_back and the defines header
`timescale 1ns / 1ps
`include "point_near_great_circle_arc_test_top_defines.svh"

module point_near_great_circle_arc_test_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pnga_pkg::in_t    item,
  output logic             result_valid,
  output pnga_pkg::res_t   result,
  input  logic             cfg_wr,
  input  logic             cfg_idx,
  input  logic [31:0]      cfg_data
);

  // configuration registers
  pnga_pkg::word_t incl;
  logic [30:0]     lat;

  always_ff @(posedge clk) begin
    if (rst) begin
      incl <= pnga_pkg::INCLUSION_RESET;
      lat  <= pnga_pkg::LATITUDE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pnga_pkg::REG_INCLUSION: incl <= cfg_data;
        pnga_pkg::REG_LATITUDE:  lat  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic           f_valid;
  logic [63:0]    f_s;
  pnga_pkg::mid_t f_mid;
  logic           s_valid;
  logic [31:0]    s_r;
  pnga_pkg::mid_t s_mid;
  logic            d_valid;
  pnga_pkg::vec3_t d_c;
  pnga_pkg::mid_t  d_mid;

  // axis dot, projection and sum of squares
  pnga_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .in_item   (item),
    .lat       (lat),
    .out_valid (f_valid),
    .out_s     (f_s),
    .out_mid   (f_mid)
  );

  // projection length
  pnga_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_s      (f_s),
    .in_mid    (f_mid),
    .out_valid (s_valid),
    .out_r     (s_r),
    .out_mid   (s_mid)
  );

  // normalization
  pnga_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_r      (s_r),
    .in_mid    (s_mid),
    .out_valid (d_valid),
    .out_c     (d_c),
    .out_mid   (d_mid)
  );

  // closeness and result
  pnga_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_c      (d_c),
    .in_mid    (d_mid),
    .incl      (incl),
    .out_valid (result_valid),
    .out_res   (result)
  );

  // excluded points report nothing
  `PNGA_ASSERT_IMPLY(a_excluded_zero, result_valid && result.nearest_kind == pnga_pkg::KIND_EXCLUDED, result.closeness == '0 && !result.is_close)
  // the flag agrees with the threshold register
  `PNGA_ASSERT_IMPLY(a_flag_threshold, result_valid && result.is_close, result.closeness > incl)
  // every accepted transaction yields a result after the fixed latency
  `PNGA_ASSERT_DELAY(a_latency, start && !busy, pnga_pkg::LATENCY, result_valid)

endmodule

// ===== design/pnga_front.sv =====
// front section: axis dot, latitude test, projection, prescale and sum of squares
// depends on pnga_pkg
`timescale 1ns / 1ps

module pnga_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  pnga_pkg::in_t   in_item,
  input  logic [30:0]     lat,
  output logic            out_valid,
  output logic [63:0]     out_s,
  output pnga_pkg::mid_t  out_mid
);

  localparam int F = pnga_pkg::FRAC_BITS;

  pnga_pkg::vec3_t t0, a0, b0, n0;

  // unpack the transaction
  always_comb begin
    t0[0] = in_item.point_x; t0[1] = in_item.point_y; t0[2] = in_item.point_z;
    a0[0] = in_item.start_x; a0[1] = in_item.start_y; a0[2] = in_item.start_z;
    b0[0] = in_item.end_x;   b0[1] = in_item.end_y;   b0[2] = in_item.end_z;
    n0[0] = in_item.axis_x;  n0[1] = in_item.axis_y;  n0[2] = in_item.axis_z;
  end

  // stage 1: componentwise products t*n, a*b, t*a and t*b of the input vectors
  logic v1;
  pnga_pkg::vec3_t t1, a1, b1, n1;
  pnga_pkg::prod_t ptn1 [3];
  pnga_pkg::prod_t pab1 [3];
  pnga_pkg::prod_t pta1 [3];
  pnga_pkg::prod_t ptb1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    t1 <= t0; a1 <= a0; b1 <= b0; n1 <= n0;
    for (int i = 0; i < 3; i++) begin
      ptn1[i] <= pnga_pkg::mul32(t0[i], n0[i]);
      pab1[i] <= pnga_pkg::mul32(a0[i], b0[i]);
      pta1[i] <= pnga_pkg::mul32(t0[i], a0[i]);
      ptb1[i] <= pnga_pkg::mul32(t0[i], b0[i]);
    end
  end

  // stage 2: dot sums and latitude test
  pnga_pkg::dot_t d1;
  logic [pnga_pkg::DOT_W-1:0] ad1;
  logic v2;
  pnga_pkg::dot_t d2;
  pnga_pkg::vec3_t n2;
  pnga_pkg::mid_t mid2, mid2_next;

  always_comb begin
    d1  = pnga_pkg::dot_sum(ptn1[0], ptn1[1], ptn1[2]);
    ad1 = d1[pnga_pkg::DOT_W-1] ? unsigned'(-d1) : unsigned'(d1);
    mid2_next      = '0;
    mid2_next.t    = t1;
    mid2_next.a    = a1;
    mid2_next.b    = b1;
    mid2_next.ab   = pnga_pkg::dot_sum(pab1[0], pab1[1], pab1[2]);
    mid2_next.ta   = pnga_pkg::dot_sum(pta1[0], pta1[1], pta1[2]);
    mid2_next.tb   = pnga_pkg::dot_sum(ptb1[0], ptb1[1], ptb1[2]);
    mid2_next.excl = ad1 > pnga_pkg::DOT_W'(lat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    d2   <= d1;
    n2   <= n1;
    mid2 <= mid2_next;
  end

  // stage 3: d times axis; d fits a word whenever the point is not excluded
  logic v3;
  pnga_pkg::prod_t pdn3 [3];
  pnga_pkg::mid_t mid3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int i = 0; i < 3; i++) begin
      pdn3[i] <= pnga_pkg::mul32(signed'(d2[pnga_pkg::WORD_W-1:0]), n2[i]);
    end
    mid3 <= mid2;
  end

  // stage 4: projection onto the arc plane, sign and magnitude
  logic signed [pnga_pkg::PROJ_W-1:0] p3 [3];
  logic [pnga_pkg::PROJ_W-1:0] m3 [3];
  logic v4;
  logic [pnga_pkg::PROJ_W-1:0] mag4 [3];
  pnga_pkg::mid_t mid4, mid4_next;

  always_comb begin
    mid4_next = mid3;
    for (int i = 0; i < 3; i++) begin
      p3[i] = pnga_pkg::PROJ_W'(mid3.t[i])
            - pnga_pkg::PROJ_W'(signed'(pdn3[i][pnga_pkg::PROD_W-1:F]));
      m3[i] = p3[i][pnga_pkg::PROJ_W-1] ? unsigned'(-p3[i]) : unsigned'(p3[i]);
      mid4_next.neg[i] = p3[i][pnga_pkg::PROJ_W-1];
    end
    mid4_next.excl = mid3.excl | ((m3[0] == '0) && (m3[1] == '0) && (m3[2] == '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    for (int i = 0; i < 3; i++) begin
      mag4[i] <= m3[i];
    end
    mid4 <= mid4_next;
  end

  // stage 5: common right shift until every magnitude is below 2^31
  logic [pnga_pkg::PROJ_W-1:0] or4;
  logic [2:0] k4;
  logic v5;
  pnga_pkg::mid_t mid5, mid5_next;

  always_comb begin
    or4 = mag4[0] | mag4[1] | mag4[2];
    if (or4[34]) begin
      k4 = 3'd4;
    end else if (or4[33]) begin
      k4 = 3'd3;
    end else if (or4[32]) begin
      k4 = 3'd2;
    end else if (or4[31]) begin
      k4 = 3'd1;
    end else begin
      k4 = 3'd0;
    end
    mid5_next = mid4;
    for (int i = 0; i < 3; i++) begin
      mid5_next.mag[i] = pnga_pkg::MAG_W'(mag4[i] >> k4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    mid5 <= mid5_next;
  end

  // stage 6: squares
  logic v6;
  logic [pnga_pkg::SQ_W-1:0] sq6 [3];
  pnga_pkg::mid_t mid6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    for (int i = 0; i < 3; i++) begin
      sq6[i] <= pnga_pkg::SQ_W'(mid5.mag[i]) * pnga_pkg::SQ_W'(mid5.mag[i]);
    end
    mid6 <= mid5;
  end

  // stage 7: sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v6;
    end
    out_s   <= 64'(sq6[0]) + 64'(sq6[1]) + 64'(sq6[2]);
    out_mid <= mid6;
  end

endmodule

// ===== design/pnga_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on pnga_pkg
`timescale 1ns / 1ps

module pnga_isqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [63:0]     in_s,
  input  pnga_pkg::mid_t  in_mid,
  output logic            out_valid,
  output logic [31:0]     out_r,
  output pnga_pkg::mid_t  out_mid
);

  localparam int N = pnga_pkg::SQRT_STAGES;

  logic           v  [0:N];
  logic [63:0]    x  [0:N];
  logic [63:0]    rs [0:N];
  pnga_pkg::mid_t m  [0:N];

  assign v[0]  = in_valid;
  assign x[0]  = in_s;
  assign rs[0] = '0;
  assign m[0]  = in_mid;

  // each stage tries the next bit pair of the radicand
  for (genvar g = 0; g < N; g++) begin : g_step
    localparam logic [63:0] ONE = 64'd1 << (62 - 2 * g);
    logic [63:0] trial;
    logic        take;

    assign trial = rs[g] + ONE;
    assign take  = x[g] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else begin
        v[g+1] <= v[g];
      end
      x[g+1]  <= take ? x[g] - trial : x[g];
      rs[g+1] <= take ? (rs[g] >> 1) + ONE : rs[g] >> 1;
      m[g+1]  <= m[g];
    end
  end

  assign out_valid = v[N];
  assign out_r     = rs[N][31:0];
  assign out_mid   = m[N];

endmodule

// ===== design/pnga_div.sv =====
// pipelined restoring divider, three lanes, scales each magnitude by 2^FRAC_BITS / r
// depends on pnga_pkg
`timescale 1ns / 1ps

module pnga_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [31:0]      in_r,
  input  pnga_pkg::mid_t   in_mid,
  output logic             out_valid,
  output pnga_pkg::vec3_t  out_c,
  output pnga_pkg::mid_t   out_mid
);

  localparam int N  = pnga_pkg::DIV_STAGES;
  localparam int QW = pnga_pkg::Q_W;

  logic                  v   [0:N];
  logic [31:0]           r   [0:N];
  pnga_pkg::mid_t        m   [0:N];
  logic [2:0][32:0]      rem [0:N];
  logic [2:0][QW-1:0]    q   [0:N];

  // quotient stays at or below 2^FRAC_BITS, so the top dividend bits start as remainder
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem[0][i] = 33'(in_mid.mag[i] >> 1);
    end
  end

  assign v[0] = in_valid;
  assign r[0] = in_r;
  assign m[0] = in_mid;
  assign q[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_step
    localparam logic FIRST = (g == 0);
    logic [2:0][32:0] trial;
    logic [2:0]       take;

    // bring down the next dividend bit, only the lowest magnitude bit is nonzero
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {rem[g][i][31:0], FIRST ? m[g].mag[i][0] : 1'b0};
        take[i]  = trial[i] >= {1'b0, r[g]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else begin
        v[g+1] <= v[g];
      end
      for (int i = 0; i < 3; i++) begin
        rem[g+1][i] <= take[i] ? trial[i] - {1'b0, r[g]} : trial[i];
        q[g+1][i]   <= {q[g][i][QW-2:0], take[i]};
      end
      r[g+1] <= r[g];
      m[g+1] <= m[g];
    end
  end

  // restore signs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_c[i] = m[N].neg[i] ? -pnga_pkg::WORD_W'(q[N][i]) : pnga_pkg::WORD_W'(q[N][i]);
    end
  end

  assign out_valid = v[N];
  assign out_mid   = m[N];

endmodule

// ===== design/pnga_back.sv =====
// back section: dots with the normalized point, endpoint choice and threshold test
// depends on pnga_pkg
`timescale 1ns / 1ps

module pnga_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pnga_pkg::vec3_t     in_c,
  input  pnga_pkg::mid_t      in_mid,
  input  pnga_pkg::word_t     incl,
  output logic                out_valid,
  output pnga_pkg::res_t      out_res
);

  // stage 1: products with the normalized point
  logic v1;
  pnga_pkg::prod_t ptc1 [3];
  pnga_pkg::prod_t pca1 [3];
  pnga_pkg::prod_t pcb1 [3];
  pnga_pkg::mid_t mid1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      ptc1[i] <= pnga_pkg::mul32(in_mid.t[i], in_c[i]);
      pca1[i] <= pnga_pkg::mul32(in_c[i], in_mid.a[i]);
      pcb1[i] <= pnga_pkg::mul32(in_c[i], in_mid.b[i]);
    end
    mid1 <= in_mid;
  end

  // stage 2: dot sums
  logic v2;
  pnga_pkg::dot_t tc2, ca2, cb2, ab2, ta2, tb2;
  logic excl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    tc2   <= pnga_pkg::dot_sum(ptc1[0], ptc1[1], ptc1[2]);
    ca2   <= pnga_pkg::dot_sum(pca1[0], pca1[1], pca1[2]);
    cb2   <= pnga_pkg::dot_sum(pcb1[0], pcb1[1], pcb1[2]);
    ab2   <= mid1.ab;
    ta2   <= mid1.ta;
    tb2   <= mid1.tb;
    excl2 <= mid1.excl;
  end

  // stage 3: pick interior point or nearer endpoint, saturate, compare, clear excluded points
  pnga_pkg::dot_t  cl;
  pnga_pkg::word_t cl_sat;
  pnga_pkg::res_t  res_next;

  always_comb begin
    res_next = '0;
    if (ca2 > ab2 && cb2 > ab2) begin
      cl = tc2;
      res_next.nearest_kind = pnga_pkg::KIND_INTERIOR;
    end else if (ca2 > cb2) begin
      cl = ta2;
      res_next.nearest_kind = pnga_pkg::KIND_START;
    end else begin
      cl = tb2;
      res_next.nearest_kind = pnga_pkg::KIND_END;
    end
    cl_sat = pnga_pkg::sat_word(cl);
    res_next.closeness = cl_sat;
    res_next.is_close  = cl_sat > incl;
    if (excl2) begin
      res_next = '0;
      res_next.nearest_kind = pnga_pkg::KIND_EXCLUDED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    out_res <= res_next;
  end

endmodule
